@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/icf_pkg.sv @@
`default_nettype none
package icf_pkg;

    localparam int IN_W       = 96;
    localparam int OUT_W      = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ATAN_LEN   = 24;
    localparam int PRESCALE_SH = 20;

    // one degree in picodegrees is 2^12 * 5^12; the odd part is divided by reciprocal
    localparam logic [27:0] PICO_ODD = 28'd244140625;
    localparam int          PICO_TWOS = 12;
    localparam logic [63:0] HALF_PICO = 64'd500000000000;
    localparam logic signed [49:0] Z180 = 50'sd180000000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GYRO_MUL,
        S_GYRO_ADD,
        S_PITCH_RUN,
        S_PITCH_WAIT,
        S_ROLL_RUN,
        S_ROLL_WAIT,
        S_BLEND_MUL,
        S_BLEND_SUM,
        S_HEAD_RUN,
        S_HEAD_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_ROT,
        C_PREP,
        C_RECIP,
        C_BACK,
        C_FIX,
        C_DONE
    } t_cphase;

    typedef enum logic [1:0] {
        SEL_PITCH,
        SEL_ROLL,
        SEL_HEAD
    } t_atan_sel;

    typedef struct packed {
        logic      load;
        logic      gyro_mul;
        logic      gyro_add;
        logic      atan_start;
        t_atan_sel sel;
        logic      blend_mul;
        logic      blend_sum;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic atan_done;
    } t_stat;

    function automatic logic [46:0] atan_pdeg(input logic [4:0] idx);
        logic [46:0] v;
        case (idx)
            5'd0:  v = 47'd45000000000000;
            5'd1:  v = 47'd26565051177078;
            5'd2:  v = 47'd14036243467926;
            5'd3:  v = 47'd7125016348902;
            5'd4:  v = 47'd3576334374997;
            5'd5:  v = 47'd1789910608246;
            5'd6:  v = 47'd895173710211;
            5'd7:  v = 47'd447614170861;
            5'd8:  v = 47'd223810500369;
            5'd9:  v = 47'd111905677066;
            5'd10: v = 47'd55952891894;
            5'd11: v = 47'd27976452617;
            5'd12: v = 47'd13988227142;
            5'd13: v = 47'd6994113675;
            5'd14: v = 47'd3497056851;
            5'd15: v = 47'd1748528427;
            5'd16: v = 47'd874264214;
            5'd17: v = 47'd437132107;
            5'd18: v = 47'd218566053;
            5'd19: v = 47'd109283027;
            5'd20: v = 47'd54641513;
            5'd21: v = 47'd27320757;
            5'd22: v = 47'd13660378;
            5'd23: v = 47'd6830189;
            default: v = 47'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/icf_cordic.sv @@
`default_nettype none
module icf_cordic #(
    parameter int STEPS = 16,
    parameter int FB    = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire logic signed [17:0] i_y,
    input  wire logic signed [17:0] i_x,
    output logic                   o_done,
    output logic signed [FB+8:0]   o_angle
);
    localparam int ITER = (STEPS < icf_pkg::ATAN_LEN) ? STEPS : icf_pkg::ATAN_LEN;
    localparam int QB   = FB + 9;
    localparam int FW   = FB + 50;
    localparam int NW   = FB + 37;
    localparam int AB   = FB + 10;
    localparam logic [QB-1:0] LIM = QB'(180) << FB;
    // floor(2^(FB+37) / 5^12): quotient estimate from the top bits of the numerator
    localparam logic [63:0] RECIP64 = (64'd1 << (FB + 37)) / 64'(icf_pkg::PICO_ODD);
    localparam logic [AB-1:0] RECIP = AB'(RECIP64);
    localparam logic [29:0] D1 = 30'(icf_pkg::PICO_ODD);
    localparam logic [29:0] D2 = 30'(icf_pkg::PICO_ODD) << 1;

    icf_pkg::t_cphase r_phase, n_phase;
    logic signed [39:0] r_x, r_y;
    logic signed [49:0] r_z;
    logic [4:0]         r_cnt;
    logic [NW-1:0]      r_num;
    logic [QB-1:0]      r_qb;
    logic [29:0]        r_rem;
    logic [QB-1:0]      r_quo, quo_c;
    logic               r_neg;
    logic signed [17:0] xa, ya;
    logic signed [39:0] xs, ys;
    logic signed [49:0] zmag, step;
    logic               zero_in;
    logic [FW-1:0]      nfull;
    logic [AB-1:0]      num_hi;
    logic [2*AB-1:0]    qprod;
    logic [NW-1:0]      bprod, rem_full;
    logic [1:0]         qfix;

    assign zero_in = (i_x == 18'sd0) && (i_y == 18'sd0);
    assign xa      = i_x[17] ? -i_x : i_x;
    assign ya      = i_x[17] ? -i_y : i_y;
    assign xs      = r_x >>> r_cnt;
    assign ys      = r_y >>> r_cnt;
    assign step    = $signed({3'b000, icf_pkg::atan_pdeg(r_cnt)});
    assign zmag    = r_z[49] ? -r_z : r_z;

    // round half up: (|z| * 2^FB + P/2) / P, with P = 2^12 * 5^12
    assign nfull    = (FW'(zmag) << FB) + FW'(icf_pkg::HALF_PICO);
    assign num_hi   = r_num[NW-1:27];
    assign qprod    = num_hi * RECIP;
    assign bprod    = NW'(r_qb) * NW'(icf_pkg::PICO_ODD);
    assign rem_full = r_num - bprod;
    // estimate is low by at most two
    assign qfix     = (r_rem >= D2) ? 2'd2 : ((r_rem >= D1) ? 2'd1 : 2'd0);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            icf_pkg::C_IDLE: if (i_start) begin
                n_phase = zero_in ? icf_pkg::C_DONE : icf_pkg::C_ROT;
            end
            icf_pkg::C_ROT:  if (r_cnt == 5'(ITER - 1)) begin
                n_phase = icf_pkg::C_PREP;
            end
            icf_pkg::C_PREP:  n_phase = icf_pkg::C_RECIP;
            icf_pkg::C_RECIP: n_phase = icf_pkg::C_BACK;
            icf_pkg::C_BACK:  n_phase = icf_pkg::C_FIX;
            icf_pkg::C_FIX:   n_phase = icf_pkg::C_DONE;
            icf_pkg::C_DONE:  n_phase = icf_pkg::C_IDLE;
            default:          n_phase = icf_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= icf_pkg::C_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            icf_pkg::C_IDLE: begin
                r_x   <= 40'(xa) <<< icf_pkg::PRESCALE_SH;
                r_y   <= 40'(ya) <<< icf_pkg::PRESCALE_SH;
                r_z   <= i_x[17] ? (i_y[17] ? -icf_pkg::Z180 : icf_pkg::Z180) : 50'sd0;
                r_cnt <= 5'd0;
                r_quo <= '0;
                r_neg <= 1'b0;
            end
            icf_pkg::C_ROT: begin
                if (!r_y[39]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + step;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - step;
                end
                r_cnt <= r_cnt + 5'd1;
            end
            icf_pkg::C_PREP: begin
                // power-of-two part of P drops out as a shift
                r_num <= nfull[FB+48:icf_pkg::PICO_TWOS];
                r_neg <= r_z[49];
            end
            icf_pkg::C_RECIP: begin
                r_qb <= qprod[AB+QB-1:AB];
            end
            icf_pkg::C_BACK: begin
                r_rem <= rem_full[29:0];
            end
            icf_pkg::C_FIX: begin
                r_quo <= r_qb + QB'(qfix);
            end
            default: begin
            end
        endcase
    end

    assign quo_c   = (r_quo > LIM) ? LIM : r_quo;
    assign o_done  = (r_phase == icf_pkg::C_DONE);
    assign o_angle = r_neg ? -$signed({1'b0, quo_c[QB-2:0]}) : $signed({1'b0, quo_c[QB-2:0]});

endmodule
`default_nettype wire

@@ rtl/core/icf_dp.sv @@
`default_nettype none
module icf_dp #(
    parameter int STEPS = 16,
    parameter int FB    = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [icf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [icf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire [icf_pkg::IN_W-1:0]              i_in_data,
    input  wire icf_pkg::t_cmd                   i_cmd,
    output icf_pkg::t_stat                       o_stat,
    output logic [icf_pkg::OUT_W-1:0]            o_out_data
);
    localparam int AW = FB + 9;
    localparam int HW = (AW > 25) ? AW : 25;
    localparam int SH = 32 - FB;
    localparam logic signed [50:0] HALF = 51'sd1 <<< (SH - 1);

    logic [31:0] r_gain;
    logic [10:0] r_low, r_high;
    logic [8:0]  r_flip;
    logic [15:0] r_weight;

    logic [icf_pkg::IN_W-1:0] r_in;
    logic signed [31:0] r_pitch, r_roll;
    logic               r_flag;
    logic signed [48:0] r_px, r_py;
    logic signed [AW-1:0] r_pa, r_ra, r_head;
    logic signed [49:0] r_mp, r_mpa, r_mr, r_mra;
    logic               r_snap;
    logic [icf_pkg::OUT_W-1:0] r_out;

    logic signed [15:0] gx, gy, mx, my;
    logic signed [10:0] axe, aye, aze, axa, aya, aza;
    logic [10:0]        l1;
    logic signed [17:0] axm, aym, azm, cy, cx;
    logic signed [50:0] sx, sy, dx, dy;
    logic signed [32:0] gain_s;
    logic signed [17:0] w_s, rw_s;
    logic signed [33:0] dp, dr, dpa, dra, lim;
    logic signed [49:0] bp, br;
    logic signed [HW-1:0] hx;
    logic               cdone;
    logic signed [AW-1:0] cang;

    assign gx  = r_in[15:0];
    assign gy  = r_in[31:16];
    assign axe = 11'($signed(r_in[41:32]));
    assign aye = 11'($signed(r_in[51:42]));
    assign aze = 11'($signed(r_in[61:52]));
    assign mx  = r_in[77:62];
    assign my  = r_in[93:78];

    assign axa = axe[10] ? -axe : axe;
    assign aya = aye[10] ? -aye : aye;
    assign aza = aze[10] ? -aze : aze;
    assign l1  = axa + aya + aza;
    assign o_stat.in_range = (l1 > r_low) && (l1 < r_high);

    // upside-down vector is mirrored before the pitch and roll arctangents
    assign axm = aze[10] ? -18'(axe) : 18'(axe);
    assign aym = aze[10] ? -18'(aye) : 18'(aye);
    assign azm = 18'(aza);

    always_comb begin
        case (i_cmd.sel)
            icf_pkg::SEL_PITCH: begin
                cy = aym;
                cx = azm;
            end
            icf_pkg::SEL_ROLL: begin
                cy = axm;
                cx = azm;
            end
            default: begin
                cy = 18'(mx);
                cx = 18'(my);
            end
        endcase
    end

    icf_cordic #(.STEPS(STEPS), .FB(FB)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.atan_start),
        .i_y     (cy),
        .i_x     (cx),
        .o_done  (cdone),
        .o_angle (cang)
    );
    assign o_stat.atan_done = cdone;

    assign gain_s = $signed({1'b0, r_gain});
    assign sx = 51'(r_px) + HALF;
    assign sy = 51'(r_py) + HALF;
    assign dx = sx >>> SH;
    assign dy = sy >>> SH;

    assign w_s  = $signed({2'b00, r_weight});
    assign rw_s = 18'sd65536 - w_s;
    assign dp   = 34'(r_pa) - 34'(r_pitch);
    assign dr   = 34'(r_ra) - 34'(r_roll);
    assign dpa  = dp[33] ? -dp : dp;
    assign dra  = dr[33] ? -dr : dr;
    assign lim  = $signed({25'd0, r_flip}) <<< FB;
    assign bp   = (r_mp + r_mpa + 50'sd32768) >>> 16;
    assign br   = (r_mr + r_mra + 50'sd32768) >>> 16;
    assign hx   = HW'(r_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 32'd2987803;
            r_low    <= 11'd256;
            r_high   <= 11'd512;
            r_flip   <= 9'd90;
            r_weight <= 16'd64225;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icf_pkg::CFG_GAIN:   r_gain   <= i_cfg_data;
                icf_pkg::CFG_LOW:    r_low    <= i_cfg_data[10:0];
                icf_pkg::CFG_HIGH:   r_high   <= i_cfg_data[10:0];
                icf_pkg::CFG_FLIP:   r_flip   <= i_cfg_data[8:0];
                icf_pkg::CFG_WEIGHT: r_weight <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_roll  <= '0;
            r_flag  <= 1'b0;
        end else if (i_cmd.gyro_add) begin
            r_pitch <= icf_pkg::sat32(64'(r_pitch) + 64'(dx));
            r_roll  <= icf_pkg::sat32(64'(r_roll) - 64'(dy));
            if (o_stat.in_range) begin
                r_flag <= aze[10];
            end
        end else if (i_cmd.blend_sum) begin
            if (r_snap) begin
                r_pitch <= 32'(r_pa);
                r_roll  <= 32'(r_ra);
            end else begin
                r_pitch <= icf_pkg::sat32(64'(bp));
                r_roll  <= icf_pkg::sat32(64'(br));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.gyro_mul) begin
            r_px <= gx * gain_s;
            r_py <= gy * gain_s;
        end
        if (cdone) begin
            case (i_cmd.sel)
                icf_pkg::SEL_PITCH: r_pa   <= cang;
                icf_pkg::SEL_ROLL:  r_ra   <= cang;
                default:            r_head <= cang;
            endcase
        end
        if (i_cmd.blend_mul) begin
            r_mp   <= r_pitch * w_s;
            r_mpa  <= r_pa * rw_s;
            r_mr   <= r_roll * w_s;
            r_mra  <= r_ra * rw_s;
            r_snap <= (dpa > lim) || (dra > lim);
        end
        if (i_cmd.out_load) begin
            r_out <= {6'd0, r_flag, hx[24:0], r_roll, r_pitch};
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

@@ rtl/core/icf_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"
module icf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    input  wire icf_pkg::t_stat  i_stat,
    output icf_pkg::t_cmd        o_cmd
);
    icf_pkg::t_state r_state, n_state;
    logic            r_ovalid;
    logic            out_free;
    logic            in_wait;

    assign out_free = !r_ovalid || i_m_tready;
    assign in_wait  = (r_state == icf_pkg::S_PITCH_WAIT) ||
                      (r_state == icf_pkg::S_ROLL_WAIT) ||
                      (r_state == icf_pkg::S_HEAD_WAIT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            icf_pkg::S_IDLE:       if (i_s_tvalid) begin
                n_state = icf_pkg::S_GYRO_MUL;
            end
            icf_pkg::S_GYRO_MUL:   n_state = icf_pkg::S_GYRO_ADD;
            icf_pkg::S_GYRO_ADD:   n_state = i_stat.in_range ? icf_pkg::S_PITCH_RUN
                                                             : icf_pkg::S_HEAD_RUN;
            icf_pkg::S_PITCH_RUN:  n_state = icf_pkg::S_PITCH_WAIT;
            icf_pkg::S_PITCH_WAIT: if (i_stat.atan_done) begin
                n_state = icf_pkg::S_ROLL_RUN;
            end
            icf_pkg::S_ROLL_RUN:   n_state = icf_pkg::S_ROLL_WAIT;
            icf_pkg::S_ROLL_WAIT:  if (i_stat.atan_done) begin
                n_state = icf_pkg::S_BLEND_MUL;
            end
            icf_pkg::S_BLEND_MUL:  n_state = icf_pkg::S_BLEND_SUM;
            icf_pkg::S_BLEND_SUM:  n_state = icf_pkg::S_HEAD_RUN;
            icf_pkg::S_HEAD_RUN:   n_state = icf_pkg::S_HEAD_WAIT;
            icf_pkg::S_HEAD_WAIT:  if (i_stat.atan_done) begin
                n_state = icf_pkg::S_OUT;
            end
            icf_pkg::S_OUT:        if (out_free) begin
                n_state = icf_pkg::S_IDLE;
            end
            default:               n_state = icf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.sel        = icf_pkg::SEL_HEAD;
        o_cmd.load       = (r_state == icf_pkg::S_IDLE) && i_s_tvalid;
        o_cmd.gyro_mul   = (r_state == icf_pkg::S_GYRO_MUL);
        o_cmd.gyro_add   = (r_state == icf_pkg::S_GYRO_ADD);
        o_cmd.atan_start = (r_state == icf_pkg::S_PITCH_RUN) ||
                           (r_state == icf_pkg::S_ROLL_RUN) ||
                           (r_state == icf_pkg::S_HEAD_RUN);
        o_cmd.blend_mul  = (r_state == icf_pkg::S_BLEND_MUL);
        o_cmd.blend_sum  = (r_state == icf_pkg::S_BLEND_SUM);
        o_cmd.out_load   = (r_state == icf_pkg::S_OUT) && out_free;
        case (r_state)
            icf_pkg::S_PITCH_RUN, icf_pkg::S_PITCH_WAIT: o_cmd.sel = icf_pkg::SEL_PITCH;
            icf_pkg::S_ROLL_RUN, icf_pkg::S_ROLL_WAIT:   o_cmd.sel = icf_pkg::SEL_ROLL;
            default:                                     o_cmd.sel = icf_pkg::SEL_HEAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= icf_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == icf_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;

    `ASSERT_NEVER(a_no_overwrite, o_cmd.out_load && r_ovalid && !i_m_tready, "result overwritten")
    `ASSERT_CLK(a_done_in_wait, i_stat.atan_done |-> in_wait, "atan done outside wait")
    `ASSERT_CLK(a_out_sets_valid, o_cmd.out_load |=> (o_m_tvalid && r_state == icf_pkg::S_IDLE), "result not presented")

endmodule
`default_nettype wire

@@ rtl/core/imu_complementary_tilt_filter.sv @@
// Complementary pitch/roll tilt filter with magnetometer heading.
// Input stream: one IMU sample per request on i_s_*; output stream: one
// result per sample on o_m_*. Config: write i_cfg_data to register
// i_cfg_index while i_cfg_we is high; write only while the block is idle.
// Each sample runs a gyro multiply and saturating add, then up to three
// arctangents on one shared CORDIC unit. Each arctangent begins with a
// start state, runs CORDIC_STEPS rotations (at most 24) and then turns
// picodegrees into the angle format (shift, reciprocal multiply,
// back-multiply, fix-up, done); a zero vector skips straight to done.
// A sample in the correction band runs the pitch and roll arctangents,
// the blend multiply and sum, then the heading; outside the band only
// the heading runs.
// The next sample is taken as soon as a result is placed in the output
// register; if the receiver stalls, the following result waits in the
// core until that register is taken. Reset (synchronous, active low)
// clears pitch, roll, the inverted flag, the handshake state and restores
// the default configuration.
`default_nettype none
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS        = 16,
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    // gyro_rate_x[15:0], gyro_rate_y[31:16], accel_x[41:32], accel_y[51:42],
    // accel_z[61:52], magnet_x[77:62], magnet_y[93:78], zero fill
    input  wire [95:0] i_s_tdata,
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    // pitch_out[31:0], roll_out[63:32], heading_out[88:64], inverted[89], zero fill
    output logic [95:0] o_m_tdata,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data
);
    icf_pkg::t_cmd  cmd;
    icf_pkg::t_stat stat;

    icf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    icf_dp #(.STEPS(CORDIC_STEPS), .FB(ANGLE_FRACTION_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_m_tdata)
    );

endmodule
`default_nettype wire
